FILE: src/pbru_pkg.sv
// Shared types and constants for the packed Bayer raw unpacker.
package pbru_pkg;

   // Packing format codes as written to the format register
   typedef enum logic [1:0] {
      FMT_RAW10 = 2'd0,
      FMT_RAW12 = 2'd1,
      FMT_RAW14 = 2'd2
   } fmt_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PACKING_FORMAT   = 2'd0,
      CSR_ROW_WIDTH_QUADS  = 2'd1,
      CSR_ROW_STRIDE_BYTES = 2'd2
   } csr_index_type;

   localparam int FormatWidth = 2;
   localparam int QuadsWidth  = 13;
   localparam int StrideWidth = 16;
   localparam int ActiveWidth = 16;
   localparam int PixelWidth  = 14;
   localparam int GroupPixels = 4;

   // Upper bound applied to the row stride
   localparam logic [19:0] MAX_ROW_BYTES = 20'd65535;

   localparam logic [FormatWidth-1:0] FormatReset = 2'd0;
   localparam logic [QuadsWidth-1:0]  QuadsReset  = 13'd1;
   localparam logic [StrideWidth-1:0] StrideReset = 16'd5;

   // One group of results handed from the unpack stage to the output buffer
   typedef struct packed {
      logic [GroupPixels-1:0][PixelWidth-1:0] pix;
      logic [2:0]                             count;
      logic                                   row_end;
      logic                                   err;
   } group_type;

endpackage

FILE: src/pbru_core.sv
// Unpack stage: group and row position tracking, byte stores, pixel assembly.
module pbru_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pbru_pkg::FormatWidth-1:0]    fmt,
   input  logic [pbru_pkg::QuadsWidth-1:0]     quads_cfg,
   input  logic [pbru_pkg::StrideWidth-1:0]    stride_cfg,
   input  logic [7:0]                          byte_in,
   input  logic                                advance,
   output logic                                needs_out,
   output pbru_pkg::group_type                 group
);

   logic [2:0]                          group_pos_ff, group_pos_in;
   logic [pbru_pkg::StrideWidth-1:0]    row_pos_ff, row_pos_in;
   logic [7:0]                          high_ff [pbru_pkg::GroupPixels];
   logic [7:0]                          low_ff  [2];

   logic [2:0]                          group_bytes;
   logic [2:0]                          group_pix;
   logic [2:0]                          active_mult;
   logic [pbru_pkg::QuadsWidth-1:0]     quads;
   logic [pbru_pkg::ActiveWidth-1:0]    active;
   logic [pbru_pkg::StrideWidth-1:0]    stride;
   logic [pbru_pkg::StrideWidth:0]      pos_inc;
   logic [2:0]                          g;
   logic [3:0]                          g_inc;
   logic                                err;
   logic                                in_active;
   logic                                closes_group;
   logic                                store_high;
   logic                                store_low;
   pbru_pkg::fmt_type                   raw_mode;

   // Decode format; the unused code behaves as RAW14
   always_comb begin
      unique case (fmt)
         pbru_pkg::FMT_RAW10: begin
            raw_mode    = pbru_pkg::FMT_RAW10;
            group_bytes = 3'd5;
            group_pix   = 3'd4;
            active_mult = 3'd5;
         end
         pbru_pkg::FMT_RAW12: begin
            raw_mode    = pbru_pkg::FMT_RAW12;
            group_bytes = 3'd3;
            group_pix   = 3'd2;
            active_mult = 3'd6;
         end
         default: begin
            raw_mode    = pbru_pkg::FMT_RAW14;
            group_bytes = 3'd7;
            group_pix   = 3'd4;
            active_mult = 3'd7;
         end
      endcase
   end

   always_comb begin
      quads  = (quads_cfg == '0) ? pbru_pkg::QuadsWidth'(1) : quads_cfg;
      active = pbru_pkg::ActiveWidth'(quads) * pbru_pkg::ActiveWidth'(active_mult);
      if ({4'b0, stride_cfg} > pbru_pkg::MAX_ROW_BYTES)
         stride = pbru_pkg::MAX_ROW_BYTES[pbru_pkg::StrideWidth-1:0];
      else
         stride = stride_cfg;
      err          = stride < active;
      g            = (group_pos_ff >= group_bytes) ? 3'd0 : group_pos_ff;
      g_inc        = {1'b0, g} + 4'd1;
      pos_inc      = {1'b0, row_pos_ff} + 17'd1;
      in_active    = row_pos_ff < active;
      closes_group = g_inc >= {1'b0, group_bytes};
      store_high   = !err && in_active && !closes_group && (g < group_pix);
      store_low    = !err && in_active && !closes_group && (g >= group_pix);
      needs_out    = err || (in_active && closes_group);
   end

   // Next positions
   always_comb begin
      group_pos_in = group_pos_ff;
      row_pos_in   = row_pos_ff;
      if (!err) begin
         group_pos_in = g;
         if (in_active)
            group_pos_in = closes_group ? 3'd0 : g_inc[2:0];
         if (pos_inc >= {1'b0, stride}) begin
            row_pos_in   = '0;
            group_pos_in = 3'd0;
         end else begin
            row_pos_in = pos_inc[pbru_pkg::StrideWidth-1:0];
         end
      end
   end

   // Assemble the group's pixels from the stores and the closing byte
   always_comb begin
      group.pix     = '0;
      group.count   = group_pix;
      group.row_end = pos_inc == {1'b0, active};
      group.err     = 1'b0;
      if (err) begin
         group.count   = 3'd1;
         group.row_end = 1'b0;
         group.err     = 1'b1;
      end else begin
         case (raw_mode)
            pbru_pkg::FMT_RAW10: begin
               for (int i = 0; i < pbru_pkg::GroupPixels; i++)
                  group.pix[i] = {4'b0, high_ff[i], 2'(byte_in >> (2 * i))};
            end
            pbru_pkg::FMT_RAW12: begin
               group.pix[0] = {2'b0, high_ff[0], byte_in[3:0]};
               group.pix[1] = {2'b0, high_ff[1], byte_in[7:4]};
            end
            default: begin
               group.pix[0] = {high_ff[0], low_ff[0][5:0]};
               group.pix[1] = {high_ff[1], low_ff[1][3:0], low_ff[0][7:6]};
               group.pix[2] = {high_ff[2], byte_in[1:0], low_ff[1][7:4]};
               group.pix[3] = {high_ff[3], byte_in[7:2]};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= '0;
         row_pos_ff   <= '0;
      end else if (advance) begin
         group_pos_ff <= group_pos_in;
         row_pos_ff   <= row_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && store_high)
         high_ff[g[1:0]] <= byte_in;
      if (advance && store_low)
         low_ff[g[0]] <= byte_in;
   end

endmodule

FILE: src/pbru_out.sv
// Output buffer holds one group of pixels; one out per cycle while rsp_ready.
module pbru_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  pbru_pkg::group_type                 group,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbru_pkg::PixelWidth-1:0]     rsp_pixel_value,
   output logic                                rsp_group_last,
   output logic                                rsp_row_end,
   output logic                                rsp_stride_error
);

   logic [pbru_pkg::GroupPixels-1:0][pbru_pkg::PixelWidth-1:0] pix_ff;
   logic       row_end_ff;
   logic       err_ff;
   logic [2:0] left_ff, left_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;

   always_comb begin
      rsp_valid        = left_ff != 3'd0;
      take             = rsp_valid && rsp_ready;
      free             = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_ready);
      rsp_pixel_value  = pix_ff[idx_ff];
      rsp_group_last   = left_ff == 3'd1;
      rsp_row_end      = row_end_ff && (left_ff == 3'd1);
      rsp_stride_error = err_ff;
   end

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (load) begin
         left_in = group.count;
         idx_in  = 2'd0;
      end else if (take) begin
         left_in = left_ff - 3'd1;
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff     <= group.pix;
         row_end_ff <= group.row_end;
         err_ff     <= group.err;
      end
   end

endmodule

FILE: src/packed_bayer_raw_unpacker.sv
// Top level of the packed Bayer raw unpacker: input register, registers, stages.
// Takes one packed byte and returns one low-aligned pixel per cycle while neither side
// stalls. A byte is held in the input register and unpacked from there; the byte that
// closes a group loads the group's 4 (RAW12: 2) pixels into an output buffer, which
// drains one pixel per cycle while the result side is ready. A row streams at one byte
// per cycle as long as the result side keeps taking pixels. Only a byte that releases
// results waits (a group-closing byte, or any byte while the stride is too small), and
// only while the previous group is still in the output buffer. If the stride is below
// the packed row size, each byte returns a single flagged result with value 0.
// Configuration registers: 0 packing format, 1 row width in quads, 2 row stride in
// bytes; write them only while the block is idle.
module packed_bayer_raw_unpacker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_packed_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbru_pkg::PixelWidth-1:0]     rsp_pixel_value,
   output logic                                rsp_group_last,
   output logic                                rsp_row_end,
   output logic                                rsp_stride_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [pbru_pkg::StrideWidth-1:0]    csr_data
);

   logic [pbru_pkg::FormatWidth-1:0]  fmt_ff;
   logic [pbru_pkg::QuadsWidth-1:0]   quads_ff;
   logic [pbru_pkg::StrideWidth-1:0]  stride_ff;
   logic                              in_valid_ff;
   logic [7:0]                        in_byte_ff;
   logic                              advance;
   logic                              needs_out;
   logic                              out_free;
   logic                              load;
   pbru_pkg::group_type               group;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= pbru_pkg::FormatReset;
         quads_ff  <= pbru_pkg::QuadsReset;
         stride_ff <= pbru_pkg::StrideReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbru_pkg::CSR_PACKING_FORMAT:
               fmt_ff <= csr_data[pbru_pkg::FormatWidth-1:0];
            pbru_pkg::CSR_ROW_WIDTH_QUADS:
               quads_ff <= csr_data[pbru_pkg::QuadsWidth-1:0];
            pbru_pkg::CSR_ROW_STRIDE_BYTES:
               stride_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Hold the registered byte until the unpack stage can retire it
   always_comb begin
      advance   = in_valid_ff && (!needs_out || out_free);
      load      = advance && needs_out;
      req_ready = !in_valid_ff || advance;
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_ready)
         in_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_byte_ff <= req_packed_byte;
   end

   pbru_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt_ff),
      .quads_cfg  (quads_ff),
      .stride_cfg (stride_ff),
      .byte_in    (in_byte_ff),
      .advance    (advance),
      .needs_out  (needs_out),
      .group      (group)
   );

   pbru_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .group            (group),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_group_last   (rsp_group_last),
      .rsp_row_end      (rsp_row_end),
      .rsp_stride_error (rsp_stride_error)
   );

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stride_error |-> rsp_group_last && !rsp_row_end)
      else $error("stride error result must be a lone group-last result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_group_last)
      else $error("row end off a group boundary");

   assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("group loaded over undelivered pixels");

endmodule

FILE: verif/bayer_unpack_checker.sv
// Scoreboard for the packed Bayer raw unpacker: tracks register writes, predicts pixels, compares.
module bayer_unpack_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [7:0]                        req_packed_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [pbru_pkg::PixelWidth-1:0]   rsp_pixel_value,
   input  logic                              rsp_group_last,
   input  logic                              rsp_row_end,
   input  logic                              rsp_stride_error,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [pbru_pkg::StrideWidth-1:0]  csr_data,
   output int                                fail_count,
   output int                                pending_results
);

   typedef struct packed {
      logic [pbru_pkg::PixelWidth-1:0] value;
      logic                            group_last;
      logic                            row_end;
      logic                            stride_error;
   } pixel_rec_type;

   logic [pbru_pkg::FormatWidth-1:0] format_reg;
   logic [pbru_pkg::QuadsWidth-1:0]  quads_reg;
   logic [pbru_pkg::StrideWidth-1:0] stride_reg;
   logic [2:0]                       group_pos;
   logic [15:0]                      row_pos;
   logic [7:0]                       high_bytes [4];
   logic [7:0]                       low_bytes [2];
   pixel_rec_type                    pixel_queue [$];
   pixel_rec_type                    want_pix;

   task automatic check_field(input string field,
                              input logic [pbru_pkg::PixelWidth-1:0] want,
                              input logic [pbru_pkg::PixelWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Advance the row and group positions for one byte, queue the pixels it releases.
   task automatic unpack_byte(input logic [7:0] b);
      pbru_pkg::fmt_type mode;
      int                quads, group_bytes, group_pix, active, stride, pos, g, shift;
      int                bv, l0, l1;
      int                lows [4];
      pixel_rec_type     rec;
      mode = pbru_pkg::FMT_RAW14;
      if (format_reg == pbru_pkg::FMT_RAW10) mode = pbru_pkg::FMT_RAW10;
      else if (format_reg == pbru_pkg::FMT_RAW12) mode = pbru_pkg::FMT_RAW12;
      quads = (quads_reg == 0) ? 1 : int'(quads_reg);
      case (mode)
         pbru_pkg::FMT_RAW10: begin
            group_bytes = 5;
            group_pix = 4;
            active = quads * 5;
         end
         pbru_pkg::FMT_RAW12: begin
            group_bytes = 3;
            group_pix = 2;
            active = quads * 6;
         end
         default: begin
            group_bytes = 7;
            group_pix = 4;
            active = quads * 7;
         end
      endcase
      stride = int'(stride_reg);
      if (stride > int'(pbru_pkg::MAX_ROW_BYTES)) stride = int'(pbru_pkg::MAX_ROW_BYTES);
      if (stride < active) begin
         // flag the byte, leave every position alone
         rec.value = '0;
         rec.group_last = 1'b1;
         rec.row_end = 1'b0;
         rec.stride_error = 1'b1;
         pixel_queue.push_back(rec);
      end else begin
         pos = int'(row_pos);
         g = int'(group_pos);
         if (g >= group_bytes) g = 0;
         if (pos < active) begin
            if (g + 1 < group_bytes) begin
               if (g < group_pix) high_bytes[g] = b;
               else low_bytes[(g - 4) & 1] = b;
               g++;
            end else begin
               bv = int'(b);
               l0 = int'(low_bytes[0]);
               l1 = int'(low_bytes[1]);
               case (mode)
                  pbru_pkg::FMT_RAW10: begin
                     shift = 2;
                     for (int i = 0; i < 4; i++) lows[i] = (bv >> (2 * i)) & 'h03;
                  end
                  pbru_pkg::FMT_RAW12: begin
                     shift = 4;
                     lows[0] = bv & 'h0F;
                     lows[1] = (bv >> 4) & 'h0F;
                     lows[2] = 0;
                     lows[3] = 0;
                  end
                  default: begin
                     // low 6 bits of each pixel are chained across the three low bytes
                     shift = 6;
                     lows[0] = l0 & 'h3F;
                     lows[1] = ((l1 & 'h0F) << 2) | ((l0 >> 6) & 'h03);
                     lows[2] = ((bv & 'h03) << 4) | ((l1 >> 4) & 'h0F);
                     lows[3] = (bv >> 2) & 'h3F;
                  end
               endcase
               for (int i = 0; i < group_pix; i++) begin
                  rec.value = pbru_pkg::PixelWidth'((int'(high_bytes[i]) << shift) | lows[i]);
                  rec.group_last = (i + 1 == group_pix);
                  rec.row_end = (i + 1 == group_pix) && (pos + 1 == active);
                  rec.stride_error = 1'b0;
                  pixel_queue.push_back(rec);
               end
               g = 0;
            end
         end
         pos++;
         if (pos >= stride) begin
            pos = 0;
            g = 0;
         end
         row_pos = 16'(pos);
         group_pos = 3'(g);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         format_reg = pbru_pkg::FormatReset;
         quads_reg = pbru_pkg::QuadsReset;
         stride_reg = pbru_pkg::StrideReset;
         group_pos = '0;
         row_pos = '0;
         foreach (high_bytes[i]) high_bytes[i] = '0;
         foreach (low_bytes[i]) low_bytes[i] = '0;
         pixel_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pbru_pkg::CSR_PACKING_FORMAT:
                  format_reg = csr_data[pbru_pkg::FormatWidth-1:0];
               pbru_pkg::CSR_ROW_WIDTH_QUADS:
                  quads_reg = csr_data[pbru_pkg::QuadsWidth-1:0];
               pbru_pkg::CSR_ROW_STRIDE_BYTES:
                  stride_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: pixel %0d arrived with none expected", $time, rsp_pixel_value);
               fail_count++;
            end else begin
               want_pix = pixel_queue.pop_front();
               check_field("pixel_value", want_pix.value, rsp_pixel_value);
               check_field("group_last", pbru_pkg::PixelWidth'(want_pix.group_last),
                           pbru_pkg::PixelWidth'(rsp_group_last));
               check_field("row_end", pbru_pkg::PixelWidth'(want_pix.row_end),
                           pbru_pkg::PixelWidth'(rsp_row_end));
               check_field("stride_error", pbru_pkg::PixelWidth'(want_pix.stride_error),
                           pbru_pkg::PixelWidth'(rsp_stride_error));
            end
         end
         if (req_valid && req_ready) unpack_byte(req_packed_byte);
      end
      pending_results <= pixel_queue.size();
   end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the packed Bayer raw unpacker: clock, reset, stimulus and verdict.
module tb_top;

   localparam logic [1:0] FmtUnused    = 2'd3;
   localparam int         RunLimit     = 2000000;
   localparam int         SettleCycles = 8;
   localparam int         PhaseItems   = 28;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_packed_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [pbru_pkg::PixelWidth-1:0]  rsp_pixel_value;
   logic                             rsp_group_last;
   logic                             rsp_row_end;
   logic                             rsp_stride_error;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   pbru_pkg::csr_index_type          csr_index = pbru_pkg::CSR_PACKING_FORMAT;
   logic [pbru_pkg::StrideWidth-1:0] csr_data = '0;
   int                               fail_count;
   int                               pending_results;
   int                               idle_pct = 0;
   int                               stall_pct = 0;

   packed_bayer_raw_unpacker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_packed_byte  (req_packed_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_group_last   (rsp_group_last),
      .rsp_row_end      (rsp_row_end),
      .rsp_stride_error (rsp_stride_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   bayer_unpack_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_packed_byte  (req_packed_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_group_last   (rsp_group_last),
      .rsp_row_end      (rsp_row_end),
      .rsp_stride_error (rsp_stride_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic int packed_row_bytes(input logic [1:0] fmt, input int quads);
      int q;
      q = (quads == 0) ? 1 : quads;
      case (fmt)
         pbru_pkg::FMT_RAW10: return q * 5;
         pbru_pkg::FMT_RAW12: return q * 6;
         default:             return q * 7;
      endcase
   endfunction

   // Drop valid, wait out every queued pixel plus the pipeline depth.
   task automatic pause_until_empty;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] value);
      if ($urandom_range(0, 49) == 0) pause_until_empty();
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_packed_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input pbru_pkg::csr_index_type idx,
                            input logic [pbru_pkg::StrideWidth-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Unused upper data bits carry random junk that the registers must ignore.
   task automatic configure(input logic [1:0] fmt, input int quads, input int stride);
      pause_until_empty();
      csr_valid <= 1'b1;
      write_reg(pbru_pkg::CSR_PACKING_FORMAT, {14'($urandom), fmt});
      write_reg(pbru_pkg::CSR_ROW_WIDTH_QUADS, {3'($urandom), 13'(quads)});
      write_reg(pbru_pkg::CSR_ROW_STRIDE_BYTES, 16'(stride));
      csr_valid <= 1'b0;
   endtask

   initial begin
      #RunLimit;
      $display("packed_bayer_raw_unpacker: mismatch");
      $finish;
   end

   initial begin
      logic [1:0] fmt;
      int         kind, quads, active, stride, n, rows, sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one RAW10 group of all ones
      repeat (5) push_byte(8'hFF);
      configure(pbru_pkg::FMT_RAW12, 1, 6);
      repeat (3) push_byte(8'h00);
      pause_until_empty();
      repeat (3) push_byte(8'hFF);
      // unused format code decodes as RAW14, zero width as one quad, one padding byte
      configure(FmtUnused, 0, 8);
      push_byte(8'h55);
      push_byte(8'hAA);
      push_byte(8'h5A);
      push_byte(8'hA5);
      push_byte(8'h3C);
      push_byte(8'hC3);
      push_byte(8'h96);
      push_byte(8'h00);
      configure(pbru_pkg::FMT_RAW14, 8191, 0);
      push_byte(8'h81);
      push_byte(8'h7E);
      // widest row, largest stride: stops mid-group
      configure(pbru_pkg::FMT_RAW10, 8191, 65535);
      push_byte(8'h01);
      push_byte(8'h80);
      push_byte(8'hFE);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 76;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 76;
            end
            default: begin
               idle_pct = 27;
               stall_pct = 27;
            end
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            kind = $urandom_range(0, 9);
            fmt = 2'($urandom_range(0, 3));
            if (kind <= 5) begin
               // whole rows at the proper packing, a little padding
               quads = $urandom_range(0, 3);
               active = packed_row_bytes(fmt, quads);
               stride = active + $urandom_range(0, 3);
               rows = $urandom_range(1, 2);
               n = stride * rows;
            end else if (kind == 6) begin
               quads = $urandom_range(1, 8191);
               active = packed_row_bytes(fmt, quads);
               stride = $urandom_range(0, active - 1);
               n = $urandom_range(1, 4);
            end else if (kind == 7) begin
               if ($urandom_range(0, 1) == 1) quads = ($urandom_range(0, 1) == 1) ? 4096 : 8191;
               else quads = $urandom_range(1, 8191);
               active = packed_row_bytes(fmt, quads);
               stride = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(active, 65535);
               n = $urandom_range(5, 12);
            end else begin
               quads = $urandom_range(0, 8191);
               if ($urandom_range(0, 1) == 1) stride = $urandom_range(0, 8);
               else stride = $urandom_range(0, 65535);
               n = $urandom_range(3, 10);
            end
            sent += n;
            configure(fmt, quads, stride);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
         end
      end

      pause_until_empty();
      if (fail_count == 0) $display("packed_bayer_raw_unpacker: match");
      else $display("packed_bayer_raw_unpacker: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
src/pbru_pkg.sv
src/pbru_core.sv
src/pbru_out.sv
src/packed_bayer_raw_unpacker.sv
verif/bayer_unpack_checker.sv
verif/tb_top.sv
